// File: design/brvm_pkg.sv
// Package for the backtracking regex machine: codes, instruction word layout
// and the UTF-8 length helper. No dependencies.
package brvm_pkg;

   // Input operation codes.
   localparam logic [1:0] OP_LOAD_PROG = 2'd0;
   localparam logic [1:0] OP_LOAD_TEXT = 2'd1;
   localparam logic [1:0] OP_RUN       = 2'd2;

   // Instruction kinds.
   localparam logic [3:0] K_CHAR   = 4'd0;
   localparam logic [3:0] K_ANY    = 4'd1;
   localparam logic [3:0] K_LHEAD  = 4'd2;
   localparam logic [3:0] K_LTAIL  = 4'd3;
   localparam logic [3:0] K_HEAD   = 4'd4;
   localparam logic [3:0] K_TAIL   = 4'd5;
   localparam logic [3:0] K_JMP    = 4'd6;
   localparam logic [3:0] K_SPLIT  = 4'd7;
   localparam logic [3:0] K_FINISH = 4'd8;
   localparam logic [3:0] K_SAVE   = 4'd9;
   localparam logic [3:0] K_MATCH  = 4'd10;

   // Run status codes.
   localparam logic [1:0] ST_NOMATCH  = 2'd0;
   localparam logic [1:0] ST_MATCH    = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;
   localparam logic [1:0] ST_STEPS    = 2'd3;

   localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
   localparam int POS_W = 11;
   localparam int ADDR_W = 16;

   // One program word as stored.
   typedef struct packed {
      logic signed [8:0] jump_b;
      logic signed [8:0] jump_a;
      logic [7:0]        ch;
      logic [3:0]        kind;
   } instr_word_type;

   // Access request to the program and text memories.
   typedef struct packed {
      logic              prog_we;
      logic [ADDR_W-1:0] prog_waddr;
      instr_word_type    prog_wdata;
      logic [ADDR_W-1:0] prog_raddr;
      logic              text_we;
      logic [ADDR_W-1:0] text_waddr;
      logic [7:0]        text_wdata;
      logic [ADDR_W-1:0] text_raddr;
   } store_req_type;

   // Stack operation request.
   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } stack_op_type;

   // Byte count of a UTF-8 character from its lead byte.
   function automatic logic [2:0] utf8_len(input logic [7:0] c);
      logic [2:0] n;
      if (c[7] == 1'b0) n = 3'd1;
      else if (c[7:5] == 3'b110) n = 3'd2;
      else if (c[7:4] == 4'b1110) n = 3'd3;
      else if (c[7:3] == 5'b11110) n = 3'd4;
      else n = 3'd1;
      return n;
   endfunction

endpackage

// File: design/brvm_ifs.sv
// Channel interfaces of the regex machine: request, response and register
// write. Depends on brvm_pkg.
interface brvm_req_if;
   import brvm_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic [9:0]        index;
   logic [3:0]        instr_kind;
   logic [7:0]        instr_char;
   logic signed [8:0] jump_a;
   logic signed [8:0] jump_b;
   logic [7:0]        text_byte;
   logic [10:0]       text_length;
   logic              partial_mode;
   modport source (output valid, opcode, index, instr_kind, instr_char, jump_a, jump_b,
                   text_byte, text_length, partial_mode, input ready);
   modport sink (input valid, opcode, index, instr_kind, instr_char, jump_a, jump_b,
                 text_byte, text_length, partial_mode, output ready);
endinterface

interface brvm_rsp_if;
   import brvm_pkg::*;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [2:0]  capture_slot;
   logic        capture_valid;
   logic [10:0] capture_start;
   logic [10:0] capture_end;
   logic        last;
   modport source (output valid, status, capture_slot, capture_valid, capture_start,
                   capture_end, last, input ready);
   modport sink (input valid, status, capture_slot, capture_valid, capture_start,
                 capture_end, last, output ready);
endinterface

interface brvm_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// File: design/brvm_store.sv
// Program and text memories of the regex machine, one write and one
// registered read port each. Depends on brvm_pkg.
module brvm_store #(
   parameter int PROG_DEPTH = 256,
   parameter int TEXT_DEPTH = 1024
) (
   input  logic                     clock,
   input  brvm_pkg::store_req_type  req,
   output brvm_pkg::instr_word_type prog_rdata,
   output logic [7:0]               text_rdata
);
   import brvm_pkg::*;

   localparam int PAW = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
   localparam int TAW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;

   instr_word_type prog_mem [PROG_DEPTH];
   logic [7:0]     text_mem [TEXT_DEPTH];

   // Program memory port.
   always_ff @(posedge clock) begin
      if (req.prog_we) begin
         prog_mem[PAW'(req.prog_waddr)] <= req.prog_wdata;
      end
      prog_rdata <= prog_mem[PAW'(req.prog_raddr)];
   end

   // Text memory port.
   always_ff @(posedge clock) begin
      if (req.text_we) begin
         text_mem[TAW'(req.text_waddr)] <= req.text_wdata;
      end
      text_rdata <= text_mem[TAW'(req.text_raddr)];
   end

endmodule

// File: design/brvm_stack.sv
// Resume-point stack of the regex machine: a memory with a fill count,
// push at the count and registered read on pop. Depends on brvm_pkg.
module brvm_stack #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 22
) (
   input  logic                   clock,
   input  logic                   reset,
   input  brvm_pkg::stack_op_type op,
   input  logic [WIDTH-1:0]       push_data,
   output logic [WIDTH-1:0]       pop_data,
   output logic                   empty,
   output logic                   full
);
   import brvm_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;
   logic [CW-1:0]    count_dec;

   assign count_dec = count_ff - CW'(1);
   assign empty = (count_ff == '0);
   assign full  = (count_ff == CW'(DEPTH));

   // Next fill count.
   always_comb begin
      count_in = count_ff;
      if (op.clear) count_in = '0;
      else if (op.push) count_in = count_ff + CW'(1);
      else if (op.pop) count_in = count_dec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Storage: write at the count, read the top entry.
   always_ff @(posedge clock) begin
      if (op.push) begin
         mem[AW'(count_ff)] <= push_data;
      end
      pop_data <= mem[AW'(count_dec)];
   end

endmodule

// File: design/backtracking_regex_vm.sv
// Backtracking regex machine. Load requests (opcode 0 program word, 1 text
// byte) are taken one per cycle and produce no response. A run request
// (opcode 2) executes the stored program against the first text_length text
// bytes, then sends one response per capture slot, the final one with last
// set; no request is taken until the last response transaction completes.
// Each executed instruction passes through a program memory read and a
// decode, then a text byte read when it inspects a text byte; a program
// counter outside the store fails without any read. A backtrack adds a
// stack memory read, and each new start offset adds an advance step and a
// restart step. The step_limit register is written over the csr channel,
// which is always ready and must only be used while idle.
// Reset returns to idle with step_limit at 1000000 and an empty stack;
// program and text contents are kept. When the receiver stalls, the current
// response is held unchanged until taken.
module backtracking_regex_vm #(
   parameter int PROG_DEPTH  = 256,
   parameter int TEXT_DEPTH  = 1024,
   parameter int STACK_DEPTH = 64,
   parameter int SLOTS       = 8
) (
   input  logic       clock,
   input  logic       reset,
   brvm_req_if.sink   req_port,
   brvm_rsp_if.source rsp_port,
   brvm_csr_if.sink   csr_port
);
   import brvm_pkg::*;

   localparam int PCW = $clog2(PROG_DEPTH + 512) + 1;
   localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SEW = PCW + POS_W;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_START  = 8'b0000_0010,
      S_FETCH  = 8'b0000_0100,
      S_DECODE = 8'b0000_1000,
      S_TEXT   = 8'b0001_0000,
      S_POP    = 8'b0010_0000,
      S_ADV    = 8'b0100_0000,
      S_EMIT   = 8'b1000_0000
   } state_type;

   state_type             state_ff, state_in;
   logic signed [PCW-1:0] pc_ff, pc_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [POS_W-1:0]      off_ff, off_in;
   logic [POS_W-1:0]      len_ff, len_in;
   logic                  partial_ff, partial_in;
   logic [31:0]           step_ff, step_in;
   logic [31:0]           limit_ff, limit_in;
   logic [1:0]            status_ff, status_in;
   logic [SW-1:0]         slot_ff, slot_in;
   instr_word_type        word_ff, word_in;

   logic [POS_W-1:0] saved_ff [SLOTS];
   logic             cap_valid_ff [SLOTS];
   logic [POS_W-1:0] cap_start_ff [SLOTS];
   logic [POS_W-1:0] cap_end_ff [SLOTS];

   store_req_type  sreq;
   instr_word_type prog_rdata;
   logic [7:0]     text_rdata;
   stack_op_type   sop;
   logic [SEW-1:0] push_data, pop_data;
   logic           stk_empty, stk_full;

   logic             do_fail, save_we, cap_we, init_saved, cap_clear;
   logic [SW-1:0]    cur_slot;
   logic             slot_ok;
   instr_word_type   dword;
   logic [POS_W:0]   any_end, adv_off;
   logic signed [PCW-1:0] pc_a, pc_b, pc_inc;

   brvm_store #(.PROG_DEPTH(PROG_DEPTH), .TEXT_DEPTH(TEXT_DEPTH)) u_store (
      .clock(clock), .req(sreq), .prog_rdata(prog_rdata), .text_rdata(text_rdata)
   );

   brvm_stack #(.DEPTH(STACK_DEPTH), .WIDTH(SEW)) u_stack (
      .clock(clock), .reset(reset), .op(sop), .push_data(push_data),
      .pop_data(pop_data), .empty(stk_empty), .full(stk_full)
   );

   // Handshakes and response payload.
   assign req_port.ready = (state_ff == S_IDLE);
   assign csr_port.ready = 1'b1;
   assign rsp_port.valid = (state_ff == S_EMIT);
   assign rsp_port.status = status_ff;
   assign rsp_port.capture_slot = 3'(slot_ff);
   assign rsp_port.capture_valid = cap_valid_ff[slot_ff];
   assign rsp_port.capture_start = cap_valid_ff[slot_ff] ? cap_start_ff[slot_ff] : '0;
   assign rsp_port.capture_end = cap_valid_ff[slot_ff] ? cap_end_ff[slot_ff] : '0;
   assign rsp_port.last = (slot_ff == SW'(SLOTS - 1));

   // Instruction fields and derived targets.
   assign dword    = (state_ff == S_TEXT) ? word_ff : prog_rdata;
   assign cur_slot = SW'(dword.jump_a[7:0]);
   assign slot_ok  = !dword.jump_a[8] && (32'(dword.jump_a[7:0]) < SLOTS);
   assign pc_a     = pc_ff + PCW'(dword.jump_a);
   assign pc_b     = pc_ff + PCW'(dword.jump_b);
   assign pc_inc   = pc_ff + PCW'(1);
   assign any_end  = {1'b0, pos_ff} + (POS_W + 1)'(utf8_len(text_rdata));
   assign adv_off  = {1'b0, off_ff} + (POS_W + 1)'(utf8_len(text_rdata));
   assign push_data = {pc_b, pos_ff};

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      pc_in      = pc_ff;
      pos_in     = pos_ff;
      off_in     = off_ff;
      len_in     = len_ff;
      partial_in = partial_ff;
      step_in    = step_ff;
      limit_in   = limit_ff;
      status_in  = status_ff;
      slot_in    = slot_ff;
      word_in    = word_ff;
      sreq       = '0;
      sop        = '0;
      do_fail    = 1'b0;
      save_we    = 1'b0;
      cap_we     = 1'b0;
      init_saved = 1'b0;
      cap_clear  = 1'b0;

      if (csr_port.valid) limit_in = csr_port.data;

      case (state_ff)
         S_IDLE: begin
            if (req_port.valid) begin
               case (req_port.opcode)
                  OP_LOAD_PROG: begin
                     sreq.prog_we    = (32'(req_port.index) < PROG_DEPTH);
                     sreq.prog_waddr = ADDR_W'(req_port.index);
                     sreq.prog_wdata = {req_port.jump_b, req_port.jump_a,
                                        req_port.instr_char, req_port.instr_kind};
                  end
                  OP_LOAD_TEXT: begin
                     sreq.text_we    = (32'(req_port.index) < TEXT_DEPTH);
                     sreq.text_waddr = ADDR_W'(req_port.index);
                     sreq.text_wdata = req_port.text_byte;
                  end
                  OP_RUN: begin
                     len_in = (32'(req_port.text_length) > TEXT_DEPTH) ?
                              POS_W'(TEXT_DEPTH) : req_port.text_length;
                     partial_in = req_port.partial_mode;
                     step_in    = '0;
                     off_in     = '0;
                     slot_in    = '0;
                     status_in  = ST_NOMATCH;
                     cap_clear  = 1'b1;
                     if (req_port.partial_mode && req_port.text_length == '0) begin
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_START;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_START: begin
            pc_in      = '0;
            pos_in     = off_ff;
            init_saved = 1'b1;
            sop.clear  = 1'b1;
            state_in   = S_FETCH;
         end
         S_FETCH: begin
            if (step_ff >= limit_ff) begin
               status_in = ST_STEPS;
               state_in  = S_EMIT;
            end else begin
               step_in = step_ff + 32'd1;
               if (pc_ff < 0 || pc_ff >= $signed(PCW'(PROG_DEPTH))) begin
                  do_fail = 1'b1;
               end else begin
                  sreq.prog_raddr = ADDR_W'(unsigned'(pc_ff));
                  state_in = S_DECODE;
               end
            end
         end
         S_DECODE: begin
            word_in  = prog_rdata;
            state_in = S_FETCH;
            sreq.text_raddr = ADDR_W'(pos_ff);
            case (prog_rdata.kind)
               K_CHAR, K_ANY: begin
                  if (pos_ff < len_ff) state_in = S_TEXT;
                  else do_fail = 1'b1;
               end
               K_LTAIL: begin
                  if (pos_ff < len_ff) state_in = S_TEXT;
                  else pc_in = pc_inc;
               end
               K_LHEAD: begin
                  if (pos_ff == '0) begin
                     pc_in = pc_inc;
                  end else begin
                     sreq.text_raddr = ADDR_W'(pos_ff - POS_W'(1));
                     state_in = S_TEXT;
                  end
               end
               K_HEAD: begin
                  if (pos_ff == '0) pc_in = pc_inc;
                  else do_fail = 1'b1;
               end
               K_TAIL: begin
                  if (pos_ff == len_ff) pc_in = pc_inc;
                  else do_fail = 1'b1;
               end
               K_JMP: pc_in = pc_a;
               K_SPLIT: begin
                  if (stk_full) begin
                     status_in = ST_OVERFLOW;
                     state_in  = S_EMIT;
                  end else begin
                     sop.push = 1'b1;
                     pc_in    = pc_a;
                  end
               end
               K_FINISH: begin
                  status_in = ST_MATCH;
                  state_in  = S_EMIT;
               end
               K_SAVE: begin
                  save_we = slot_ok;
                  pc_in   = pc_inc;
               end
               K_MATCH: begin
                  cap_we = slot_ok;
                  pc_in  = pc_inc;
               end
               default: do_fail = 1'b1;
            endcase
         end
         S_TEXT: begin
            state_in = S_FETCH;
            case (word_ff.kind)
               K_CHAR: begin
                  if (text_rdata == word_ff.ch) begin
                     pos_in = pos_ff + POS_W'(1);
                     pc_in  = pc_inc;
                  end else begin
                     do_fail = 1'b1;
                  end
               end
               K_ANY: begin
                  if (any_end <= {1'b0, len_ff}) begin
                     pos_in = POS_W'(any_end);
                     pc_in  = pc_inc;
                  end else begin
                     do_fail = 1'b1;
                  end
               end
               K_LHEAD, K_LTAIL: begin
                  if (text_rdata == NEWLINE_BYTE) pc_in = pc_inc;
                  else do_fail = 1'b1;
               end
               default: do_fail = 1'b1;
            endcase
         end
         S_POP: begin
            pc_in    = pop_data[SEW-1:POS_W];
            pos_in   = pop_data[POS_W-1:0];
            state_in = S_FETCH;
         end
         S_ADV: begin
            if (adv_off < {1'b0, len_ff}) begin
               off_in   = POS_W'(adv_off);
               state_in = S_START;
            end else begin
               status_in = ST_NOMATCH;
               state_in  = S_EMIT;
            end
         end
         S_EMIT: begin
            if (rsp_port.ready) begin
               if (slot_ff == SW'(SLOTS - 1)) state_in = S_IDLE;
               else slot_in = slot_ff + SW'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase

      // A failed instruction backtracks, or ends the attempt.
      if (do_fail) begin
         if (!stk_empty) begin
            sop.pop  = 1'b1;
            state_in = S_POP;
         end else if (partial_ff) begin
            sreq.text_raddr = ADDR_W'(off_ff);
            state_in = S_ADV;
         end else begin
            status_in = ST_NOMATCH;
            state_in  = S_EMIT;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         limit_ff <= 32'd1000000;
         step_ff  <= '0;
         slot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         limit_ff <= limit_in;
         step_ff  <= step_in;
         slot_ff  <= slot_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      pc_ff      <= pc_in;
      pos_ff     <= pos_in;
      off_ff     <= off_in;
      len_ff     <= len_in;
      partial_ff <= partial_in;
      status_ff  <= status_in;
      word_ff    <= word_in;
   end

   // Saved positions and capture slots.
   always_ff @(posedge clock) begin
      for (int k = 0; k < SLOTS; k++) begin
         if (init_saved) saved_ff[k] <= off_ff;
      end
      if (save_we) saved_ff[cur_slot] <= pos_ff;
      if (cap_we) begin
         cap_start_ff[cur_slot] <= saved_ff[cur_slot];
         cap_end_ff[cur_slot]   <= pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SLOTS; k++) cap_valid_ff[k] <= 1'b0;
      end else if (cap_clear) begin
         for (int k = 0; k < SLOTS; k++) cap_valid_ff[k] <= 1'b0;
      end else if (cap_we) begin
         cap_valid_ff[cur_slot] <= 1'b1;
      end
   end

endmodule
